// ===== sv/slg_pkg.sv =====
package slg_pkg;

  localparam int LIN_BITS = 16;               // fraction bits of linear light
  localparam int Q        = 31;               // fraction bits of the curve math
  localparam int LIN_W    = LIN_BITS + 1;     // holds 1.0 exactly
  localparam int W_W      = 13;               // luminance weight width
  localparam int SUM_W    = LIN_BITS + 14;    // weighted sum, scaled by 10000
  localparam int SH_W     = Q - LIN_BITS;     // alignment of the sum to 0.31
  localparam int YQ_W     = SUM_W + SH_W;     // width of compared luminance
  localparam int DEPTH    = 256;
  localparam int ADDR_W   = 8;
  localparam int N_STEP   = 8;                // binary search steps

  localparam logic [W_W-1:0] W_RED   = 13'd2126;
  localparam logic [W_W-1:0] W_GREEN = 13'd7152;
  localparam logic [W_W-1:0] W_BLUE  = 13'd722;

  typedef logic [63:0] u64_t;
  typedef logic [LIN_W-1:0] lin_tab_t [DEPTH];
  typedef logic [YQ_W-1:0]  thr_tab_t [DEPTH];

  typedef struct packed {
    logic [LIN_W-1:0] red;
    logic [LIN_W-1:0] green;
    logic [LIN_W-1:0] blue;
  } lin_t;

  // restoring long division, elaboration only
  function automatic u64_t udiv(u64_t n, u64_t d);
    u64_t rem;
    u64_t quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], n[i]};
      if (rem >= d) begin
        rem    = rem - d;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic u64_t qmul(u64_t a, u64_t b);
    return (a * b + (64'd1 << (Q - 1))) >> Q;
  endfunction

  function automatic u64_t qpow5(u64_t r);
    u64_t r2;
    u64_t r4;
    r2 = qmul(r, r);
    r4 = qmul(r2, r2);
    return qmul(r4, r);
  endfunction

  // (num/den)^2.4 in 0.31 as x^2 * fifth root of x^2
  function automatic u64_t qpow24(u64_t num, u64_t den);
    u64_t x;
    u64_t x2;
    u64_t r;
    u64_t t;
    x  = udiv((num << Q) + (den >> 1), den);
    x2 = qmul(x, x);
    r  = '0;
    for (int b = Q; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t <= (64'd1 << Q) && qpow5(t) <= x2) begin
        r = t;
      end
    end
    return qmul(x2, r);
  endfunction

  function automatic lin_tab_t build_lin();
    lin_tab_t tab;
    u64_t     n;
    u64_t     v;
    for (int c = 0; c < DEPTH; c++) begin
      if (c <= 10) begin
        n      = (u64_t'(c) * 64'd25) << LIN_BITS;
        tab[c] = LIN_W'((n + 64'd41182) / 64'd82365);
      end else begin
        v      = qpow24(u64_t'(c) * 64'd1000 + 64'd14025, 64'd269025);
        tab[c] = LIN_W'((v + (64'd1 << (SH_W - 1))) >> SH_W);
      end
    end
    return tab;
  endfunction

  // decision levels scaled by the weight total of 10000
  function automatic thr_tab_t build_thr();
    thr_tab_t tab;
    u64_t     o;
    u64_t     thr;
    tab[0] = '0;
    for (int k = 1; k < DEPTH; k++) begin
      o = u64_t'(k) * 64'd2 - 64'd1;
      if (k <= 10) begin
        thr = (((o * 64'd25) << Q) + 64'd82365) / 64'd164730;
      end else begin
        thr = qpow24(o * 64'd1000 + 64'd28050, 64'd538050);
      end
      tab[k] = YQ_W'(thr * 64'd10000);
    end
    return tab;
  endfunction

  localparam lin_tab_t LIN_TAB = build_lin();
  localparam thr_tab_t THR_TAB = build_thr();

endpackage

// ===== sv/slg_ram.sv =====
module slg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== sv/slg_lin.sv =====
module slg_lin (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  blue_i,
  input  logic [7:0]                  green_i,
  input  logic [7:0]                  red_i,
  output logic                        lin_valid_o,
  input  logic                        lin_ready_i,
  output slg_pkg::lin_t               lin_o
);

  logic [slg_pkg::ADDR_W:0]   fill_cnt_q;
  logic [slg_pkg::ADDR_W:0]   fill_cnt_d;
  logic                       fill_done;
  logic [slg_pkg::ADDR_W-1:0] waddr;
  logic [slg_pkg::LIN_W-1:0]  wdata;
  logic                       lin_valid_q;
  logic                       lin_valid_d;
  logic                       st_ready;
  logic                       accept;
  logic [slg_pkg::LIN_W-1:0]  blue_dup;

  // table load pass after reset, one entry per cycle
  assign fill_done  = fill_cnt_q[slg_pkg::ADDR_W];
  assign fill_cnt_d = fill_done ? fill_cnt_q : fill_cnt_q + 1'b1;
  assign waddr      = fill_cnt_q[slg_pkg::ADDR_W-1:0];
  assign wdata      = slg_pkg::LIN_TAB[waddr];

  assign st_ready    = !lin_valid_q || lin_ready_i;
  assign in_ready_o  = fill_done && st_ready;
  assign accept      = in_valid_i && in_ready_o;
  assign lin_valid_d = st_ready ? accept : lin_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_cnt_q  <= '0;
      lin_valid_q <= 1'b0;
    end else begin
      fill_cnt_q  <= fill_cnt_d;
      lin_valid_q <= lin_valid_d;
    end
  end

  // red and green share one copy, blue reads the other
  slg_ram #(
    .WIDTH (slg_pkg::LIN_W),
    .DEPTH (slg_pkg::DEPTH)
  ) u_ram_rg (
    .clk_i     (clk_i),
    .we_i      (!fill_done),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .re_i      (st_ready),
    .raddr_a_i (red_i),
    .raddr_b_i (green_i),
    .rdata_a_o (lin_o.red),
    .rdata_b_o (lin_o.green)
  );

  slg_ram #(
    .WIDTH (slg_pkg::LIN_W),
    .DEPTH (slg_pkg::DEPTH)
  ) u_ram_b (
    .clk_i     (clk_i),
    .we_i      (!fill_done),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .re_i      (st_ready),
    .raddr_a_i (blue_i),
    .raddr_b_i (blue_i),
    .rdata_a_o (lin_o.blue),
    .rdata_b_o (blue_dup)
  );

  assign lin_valid_o = lin_valid_q;

  a_no_accept_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fill_done |-> !in_ready_o)
    else $error("item taken while table load is running");

  a_fill_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fill_done |=> fill_cnt_q == $past(fill_cnt_q) + 1'b1)
    else $error("table load counter skipped");

  a_fill_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_done |=> fill_done)
    else $error("table load restarted without reset");

  a_ports_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lin_valid_q |-> blue_dup == lin_o.blue)
    else $error("blue table read ports disagree");

endmodule

// ===== sv/slg_wsum.sv =====
module slg_wsum (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       lin_valid_i,
  output logic                       lin_ready_o,
  input  slg_pkg::lin_t              lin_i,
  output logic                       sum_valid_o,
  input  logic                       sum_ready_i,
  output logic [slg_pkg::SUM_W-1:0]  sum_o
);

  logic [slg_pkg::SUM_W-1:0] pr_q, pg_q, pb_q;
  logic [slg_pkg::SUM_W-1:0] pr_d, pg_d, pb_d;
  logic [slg_pkg::SUM_W-1:0] sum_q, sum_d;
  logic                      p_valid_q, p_valid_d;
  logic                      s_valid_q, s_valid_d;
  logic                      p_rdy, s_rdy;

  assign s_rdy       = !s_valid_q || sum_ready_i;
  assign p_rdy       = !p_valid_q || s_rdy;
  assign lin_ready_o = p_rdy;

  assign pr_d = slg_pkg::SUM_W'(lin_i.red)   * slg_pkg::SUM_W'(slg_pkg::W_RED);
  assign pg_d = slg_pkg::SUM_W'(lin_i.green) * slg_pkg::SUM_W'(slg_pkg::W_GREEN);
  assign pb_d = slg_pkg::SUM_W'(lin_i.blue)  * slg_pkg::SUM_W'(slg_pkg::W_BLUE);
  // weights add to 10000, so the sum cannot exceed 10000 * 2^LIN_BITS
  assign sum_d = pr_q + pg_q + pb_q;

  assign p_valid_d = p_rdy ? lin_valid_i : p_valid_q;
  assign s_valid_d = s_rdy ? p_valid_q : s_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
    end else begin
      p_valid_q <= p_valid_d;
      s_valid_q <= s_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_rdy) begin
      pr_q <= pr_d;
      pg_q <= pg_d;
      pb_q <= pb_d;
    end
    if (s_rdy) begin
      sum_q <= sum_d;
    end
  end

  assign sum_valid_o = s_valid_q;
  assign sum_o       = sum_q;

endmodule

// ===== sv/slg_search.sv =====
module slg_search (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       sum_valid_i,
  output logic                       sum_ready_o,
  input  logic [slg_pkg::SUM_W-1:0]  sum_i,
  output logic                       gray_valid_o,
  input  logic                       gray_ready_i,
  output logic [7:0]                 gray_o
);

  localparam int NS = slg_pkg::N_STEP;

  logic [slg_pkg::SUM_W-1:0] sum_q  [NS];
  logic [7:0]                g_q    [NS];
  logic [7:0]                g_d    [NS];
  logic [slg_pkg::SUM_W-1:0] src_sum[NS];
  logic [7:0]                src_g  [NS];
  logic [7:0]                probe  [NS];
  logic [slg_pkg::YQ_W-1:0]  yq     [NS];
  logic [NS-1:0]             v_q, v_d;
  logic [NS:0]               rdy;

  always_comb begin
    rdy[NS] = gray_ready_i;
    for (int i = NS - 1; i >= 0; i--) begin
      rdy[i] = !v_q[i] || rdy[i+1];
    end
  end

  // one result bit per stage, msb first
  always_comb begin
    for (int i = 0; i < NS; i++) begin
      if (i == 0) begin
        src_sum[i] = sum_i;
        src_g[i]   = '0;
        v_d[i]     = rdy[i] ? sum_valid_i : v_q[i];
      end else begin
        src_sum[i] = sum_q[i-1];
        src_g[i]   = g_q[i-1];
        v_d[i]     = rdy[i] ? v_q[i-1] : v_q[i];
      end
      probe[i] = src_g[i] | (8'd1 << (NS - 1 - i));
      yq[i]    = {src_sum[i], {slg_pkg::SH_W{1'b0}}};
      // on the level itself counts as reaching it
      g_d[i]   = (yq[i] >= slg_pkg::THR_TAB[probe[i]]) ? probe[i] : src_g[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NS; i++) begin
      if (rdy[i]) begin
        sum_q[i] <= src_sum[i];
        g_q[i]   <= g_d[i];
      end
    end
  end

  assign sum_ready_o  = rdy[0];
  assign gray_valid_o = v_q[NS-1];
  assign gray_o       = g_q[NS-1];

  a_first_step_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] |-> g_q[0][6:0] == 7'd0)
    else $error("search decided low bits too early");

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[NS-1] |-> sum_ready_o)
    else $error("search pipe stalls with an empty output stage");

  a_bits_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rdy[1] && v_q[0] |=> v_q[1] && g_q[1][7] == $past(g_q[0][7]))
    else $error("decided bit changed between stages");

endmodule

// ===== sv/srgb_luminance_grayscale_core.sv =====
// sRGB pixel to gamma-correct gray level, BT.709 luminance weights.
//
// Input channel: in_valid_i / in_ready_o with blue_i, green_i, red_i, one
// sRGB byte each. Output channel: out_valid_o / out_ready_i with gray_o.
// An item moves on a rising edge where valid and ready are both high.
//
// Each byte is linearized through a 256-entry table held in two dual-read
// RAMs, weighted and summed, then re-encoded by an 8-step binary search over
// constant decision levels, one result bit per stage.
// gray_o comes out of registers for the RAM read, multiply, sum and eight
// search stages. Throughput: one pixel per cycle while out_ready_i is high.
//
// After reset the block loads the table RAMs, one entry per cycle, and holds
// in_ready_o low until every entry is written. When the receiver stalls, items
// collect in the empty stages ahead of the output register, so input is
// still taken until every stage holds an item.
module srgb_luminance_grayscale_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] blue_i,
  input  logic [7:0] green_i,
  input  logic [7:0] red_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] gray_o
);

  slg_pkg::lin_t             lin;
  logic                      lin_valid;
  logic                      lin_ready;
  logic [slg_pkg::SUM_W-1:0] sum;
  logic                      sum_valid;
  logic                      sum_ready;

  slg_lin u_lin (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .blue_i      (blue_i),
    .green_i     (green_i),
    .red_i       (red_i),
    .lin_valid_o (lin_valid),
    .lin_ready_i (lin_ready),
    .lin_o       (lin)
  );

  slg_wsum u_wsum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lin_valid_i (lin_valid),
    .lin_ready_o (lin_ready),
    .lin_i       (lin),
    .sum_valid_o (sum_valid),
    .sum_ready_i (sum_ready),
    .sum_o       (sum)
  );

  slg_search u_search (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sum_valid_i  (sum_valid),
    .sum_ready_o  (sum_ready),
    .sum_i        (sum),
    .gray_valid_o (out_valid_o),
    .gray_ready_i (out_ready_i),
    .gray_o       (gray_o)
  );

endmodule
